// ----- src/tlw_pkg.sv -----
// ----------------------------------------------------------------------------
// tlw_pkg: shared types and constants for the tlv length widener
// message phases, status codes, result beat and transcoder state types
// ----------------------------------------------------------------------------
package tlw_pkg;

  localparam int BYTE_W  = 8;
  localparam int HL_W    = 3;
  localparam int VL_W    = 15;
  localparam int LH_W    = 7;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  localparam logic [BYTE_W-1:0] TYPE_LONG_A = 8'h00;
  localparam logic [BYTE_W-1:0] TYPE_LONG_B = 8'h01;
  localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h00;
  localparam logic [HL_W-1:0]   HDR_LEFT_LONG = 3'd7;  // 8-byte header minus the type

  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_TAG = 6'b000100,
    PH_LEN = 6'b001000,
    PH_LENLO = 6'b010000,
    PH_VALUE = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SHORTHDR = 2'd1,
    ST_SHORTTL = 2'd2,
    ST_SHORTVAL = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    status_t           status;
  } beat_t;

  typedef struct packed {
    phase_t            phase;
    logic [HL_W-1:0]   header_left;
    logic [VL_W-1:0]   value_left;
    logic [LH_W-1:0]   length_high;
  } xstate_t;

endpackage

// ----- src/tlw_xcode.sv -----
// ----------------------------------------------------------------------------
// tlw_xcode: per-byte transcoder
// next parse state and one or two result beats for the current byte
// ----------------------------------------------------------------------------
module tlw_xcode (
  input  tlw_pkg::xstate_t                 cur,
  input  logic [tlw_pkg::BYTE_W-1:0]       data,
  input  logic                             last,
  output tlw_pkg::xstate_t                 nxt,
  output logic                             two,
  output tlw_pkg::beat_t                   res0,
  output tlw_pkg::beat_t                   res1
);

  tlw_pkg::status_t            st;
  logic [tlw_pkg::HL_W-1:0]    hl_dec;
  logic [tlw_pkg::VL_W-1:0]    vl_dec;
  logic [tlw_pkg::VL_W-1:0]    vl_long;
  logic [tlw_pkg::VL_W-1:0]    vl_short;

  assign hl_dec   = cur.header_left - 3'd1;
  assign vl_dec   = cur.value_left - 15'd1;
  assign vl_long  = {cur.length_high, data};
  assign vl_short = {8'd0, data[6:0]};

  always_comb begin
    nxt = cur;
    two = 1'b0;
    st  = tlw_pkg::ST_OK;
    case (cur.phase)
      tlw_pkg::PH_HEADER: begin
        nxt.header_left = hl_dec;
        if (hl_dec == '0) begin
          nxt.phase = tlw_pkg::PH_TAG;
        end
        st = (hl_dec == '0) ? tlw_pkg::ST_OK : tlw_pkg::ST_SHORTHDR;
      end
      tlw_pkg::PH_TAG: begin
        nxt.phase = tlw_pkg::PH_LEN;
        st        = tlw_pkg::ST_SHORTTL;
      end
      tlw_pkg::PH_LEN: begin
        if (data[7]) begin
          // short length widens to a zero byte and the length
          two            = 1'b1;
          nxt.value_left = vl_short;
          nxt.phase      = (vl_short != '0) ? tlw_pkg::PH_VALUE : tlw_pkg::PH_TAG;
          st             = (vl_short != '0) ? tlw_pkg::ST_SHORTVAL : tlw_pkg::ST_OK;
        end else begin
          nxt.length_high = data[6:0];
          nxt.phase       = tlw_pkg::PH_LENLO;
          st              = tlw_pkg::ST_SHORTTL;
        end
      end
      tlw_pkg::PH_LENLO: begin
        nxt.value_left = vl_long;
        nxt.phase      = (vl_long != '0) ? tlw_pkg::PH_VALUE : tlw_pkg::PH_TAG;
        st             = (vl_long != '0) ? tlw_pkg::ST_SHORTVAL : tlw_pkg::ST_OK;
      end
      tlw_pkg::PH_VALUE: begin
        nxt.value_left = vl_dec;
        if (vl_dec == '0) begin
          nxt.phase = tlw_pkg::PH_TAG;
        end
        st = (vl_dec != '0) ? tlw_pkg::ST_SHORTVAL : tlw_pkg::ST_OK;
      end
      default: begin
        // start of message: the type byte picks the header size
        if (data == tlw_pkg::TYPE_LONG_A || data == tlw_pkg::TYPE_LONG_B) begin
          nxt.header_left = tlw_pkg::HDR_LEFT_LONG;
          nxt.phase       = tlw_pkg::PH_HEADER;
          st              = tlw_pkg::ST_SHORTHDR;
        end else begin
          nxt.header_left = '0;
          nxt.phase       = tlw_pkg::PH_TAG;
          st              = tlw_pkg::ST_OK;
        end
      end
    endcase
    if (last) begin
      nxt.phase       = tlw_pkg::PH_START;
      nxt.header_left = '0;
      nxt.value_left  = '0;
      nxt.length_high = '0;
    end
  end

  always_comb begin
    res1.data   = {1'b0, data[6:0]};
    res1.last   = last;
    res1.status = last ? st : tlw_pkg::ST_OK;
    if (two) begin
      res0.data   = tlw_pkg::PAD_BYTE;
      res0.last   = 1'b0;
      res0.status = tlw_pkg::ST_OK;
    end else begin
      res0.data   = data;
      res0.last   = last;
      res0.status = last ? st : tlw_pkg::ST_OK;
    end
  end

endmodule

// ----- src/tlw_outq.sv -----
// ----------------------------------------------------------------------------
// tlw_outq: result queue
// four-entry queue taking up to two beats per cycle, handing out one
// ----------------------------------------------------------------------------
module tlw_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          push_two,
  input  tlw_pkg::beat_t                beat0,
  input  tlw_pkg::beat_t                beat1,
  output logic                          room,
  output logic                          q_valid,
  input  logic                          q_ready,
  output tlw_pkg::beat_t                q_beat,
  output logic [tlw_pkg::Q_CW-1:0]      q_count
);

  tlw_pkg::beat_t                 mem_r [tlw_pkg::Q_DEPTH];
  logic [tlw_pkg::Q_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tlw_pkg::Q_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tlw_pkg::Q_CW-1:0]       count_r, count_nxt;
  logic [tlw_pkg::Q_CW-1:0]       n_push;
  logic                           pop;

  // room for two beats, judged on the registered count
  assign room    = (count_r <= 3'd2);
  assign q_valid = (count_r != '0);
  assign q_beat  = mem_r[rd_ptr_r];
  assign q_count = count_r;
  assign pop     = q_valid && q_ready;
  assign n_push  = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[tlw_pkg::Q_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(tlw_pkg::Q_AW-1){1'b0}}, pop};
    count_nxt  = count_r + n_push - {{(tlw_pkg::Q_CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= beat0;
      if (push_two) begin
        mem_r[wr_ptr_r + 2'd1] <= beat1;
      end
    end
  end

endmodule

// ----- src/tlv_length_widener_top.sv -----
// ----------------------------------------------------------------------------
// tlv_length_widener_top: tlv length widener
// rewrites every tlv entry of a byte stream so its length takes two bytes
// ----------------------------------------------------------------------------
// output: an accepted byte waits in the input register until the queue has
//   room, then is pushed into the result queue, whose count raises out_valid
// throughput: one input beat per cycle while the queue has room for two;
//   a short length byte yields two beats for the one-beat output port
// reset: rst_n synchronous active low clears the parse state, the input
//   register and the result queue; parsing restarts at a message type byte
module tlv_length_widener_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  // input register
  logic                             s1_valid_r, s1_valid_nxt;
  logic [tlw_pkg::BYTE_W-1:0]       s1_byte_r;
  logic                             s1_last_r;
  logic                             s1_fire;
  logic                             in_fire;

  // parse state
  tlw_pkg::xstate_t                 st_r, st_nxt;

  // transcoder results
  logic                             two;
  tlw_pkg::beat_t                   res0, res1;

  // result queue
  logic                             q_room;
  tlw_pkg::beat_t                   q_beat;
  logic [tlw_pkg::Q_CW-1:0]         q_count;

  // the registered byte moves on once the queue has room for two beats
  assign s1_fire  = s1_valid_r && q_room;
  assign in_ready = !s1_valid_r || q_room;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  tlw_xcode u_xcode (
    .cur  (st_r),
    .data (s1_byte_r),
    .last (s1_last_r),
    .nxt  (st_nxt),
    .two  (two),
    .res0 (res0),
    .res1 (res1)
  );

  // parse state advances only when a byte is actually consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= tlw_pkg::PH_START;
      st_r.header_left <= '0;
      st_r.value_left  <= '0;
      st_r.length_high <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  tlw_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_fire),
    .push_two (two),
    .beat0    (res0),
    .beat1    (res1),
    .room     (q_room),
    .q_valid  (out_valid),
    .q_ready  (out_ready),
    .q_beat   (q_beat),
    .q_count  (q_count)
  );

  assign out_byte   = q_beat.data;
  assign out_last   = q_beat.last;
  assign out_status = q_beat.status;

  // a final byte always sends the parser back to the start of a message
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (st_r.phase == tlw_pkg::PH_START))
    else $error("parser not at start after final byte");

  // a nonzero status only rides on the final beat
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tlw_pkg::ST_OK) |-> out_last)
    else $error("status on a non-final beat");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 3'(tlw_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // the widened zero byte is never marked final
  a_pad_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && two) |-> (!res0.last && res0.data == tlw_pkg::PAD_BYTE))
    else $error("bad widened length pad beat");

endmodule
